### rtl/e2u_pkg.sv
// Package: constants, reciprocals and types for the epoch to UTC date converter.
`default_nettype none

package e2u_pkg;

   // Pipeline depth, input register to result register.
   localparam int unsigned PIPE_STAGES = 8;

   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
   localparam logic [16:0] LAST_SEC_OF_DAY = 17'd86399;
   localparam logic [21:0] MAX_DAYS        = 22'd2932896;
   // Days from 1 Mar 1 BC to the epoch (719527 - 59); plus two for Gauss's year estimate.
   localparam logic [21:0] MARCH_OFFSET    = 22'd719468;
   localparam logic [21:0] MARCH_OFFSET_P2 = 22'd719470;
   localparam logic [21:0] EPOCH_WEEKDAY   = 22'd4;
   localparam logic [8:0]  MARCH_TO_DEC    = 9'd306;

   // Rounded-up reciprocals; each is exact over the input range it serves.
   localparam longint unsigned RECIP_675_L    = ((64'd1 << 42) + 64'd674) / 64'd675;
   localparam longint unsigned RECIP_146097_L = ((64'd1 << 49) + 64'd146096) / 64'd146097;
   localparam longint unsigned RECIP_3600_L   = ((64'd1 << 29) + 64'd3599) / 64'd3600;
   localparam longint unsigned RECIP_60_L     = ((64'd1 << 20) + 64'd59) / 64'd60;
   localparam longint unsigned RECIP_7_L      = ((64'd1 << 25) + 64'd6) / 64'd7;
   localparam longint unsigned RECIP_100_L    = ((64'd1 << 19) + 64'd99) / 64'd100;

   localparam logic [32:0] RECIP_675    = 33'(RECIP_675_L);
   localparam logic [31:0] RECIP_146097 = 32'(RECIP_146097_L);
   localparam logic [17:0] RECIP_3600   = 18'(RECIP_3600_L);
   localparam logic [14:0] RECIP_60     = 15'(RECIP_60_L);
   localparam logic [22:0] RECIP_7      = 23'(RECIP_7_L);
   localparam logic [12:0] RECIP_100    = 13'(RECIP_100_L);

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
   } date_type;

   // First day-of-year (March based) of Gauss month k, i.e. 367*k/12 - 30.
   function automatic logic [8:0] month_base(input logic [3:0] k);
      logic [8:0] base;
      unique case (k)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd61;
         4'd4:    base = 9'd92;
         4'd5:    base = 9'd122;
         4'd6:    base = 9'd153;
         4'd7:    base = 9'd184;
         4'd8:    base = 9'd214;
         4'd9:    base = 9'd245;
         4'd10:   base = 9'd275;
         4'd11:   base = 9'd306;
         4'd12:   base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

### rtl/epoch_seconds_to_utc_date.sv
// Top level: pipelined conversion of Unix seconds to UTC calendar fields.
//
// Input channel req_*: one signed 40-bit count of seconds since the epoch per
// transfer. Negative values read as the epoch itself; counts past the end of
// 9999-12-31 saturate to 9999-12-31 23:59:59.
// Result channel rsp_*: second, minute, hour, day of month, month, year and
// weekday (Sunday is zero), one transfer per input transfer, in order.
// Throughput is one item per cycle while rsp_ready does not stall the result,
// set by the 8-stage pipeline with at most one multiply deep per stage.
// All divisions are by constants and run as reciprocal multiplies.
// Each stage holds its own valid bit. A stage advances when it is empty or
// the stage after it advances, so bubbles collapse and a stalled receiver
// only backs up as far as the last empty stage; nothing is dropped or
// duplicated. req_ready falls only once all 8 stages hold items.
// Synchronous active-high reset empties the pipeline; payload is not reset.
`default_nettype none

module epoch_seconds_to_utc_date
   import e2u_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [39:0] req_epoch_seconds,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [5:0]              rsp_second,
   output logic [5:0]              rsp_minute,
   output logic [4:0]              rsp_hour,
   output logic [4:0]              rsp_day_of_month,
   output logic [3:0]              rsp_month,
   output logic [13:0]             rsp_year,
   output logic [2:0]              rsp_weekday
);

   // ---------------------------------------------------------------- control
   logic [PIPE_STAGES-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[PIPE_STAGES-1] = ~vld_ff[PIPE_STAGES-1] | rsp_ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (en[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   // ---------------------------------------------------------------- stage 1
   // Clamp negatives, then days = t / 86400 as (t >> 7) / 675.
   logic [38:0] s1_t_in, s1_t_ff;
   logic [64:0] s1_prod;
   logic [22:0] s1_days_in, s1_days_ff;

   assign s1_t_in    = req_epoch_seconds[39] ? 39'd0 : req_epoch_seconds[38:0];
   assign s1_prod    = 65'(s1_t_in[38:7]) * 65'(RECIP_675);
   assign s1_days_in = s1_prod[64:42];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_t_ff    <= s1_t_in;
         s1_days_ff <= s1_days_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Seconds into the day; flag day counts past the last supported date.
   logic [39:0] s2_diff;
   logic [16:0] s2_secs_in, s2_secs_ff;
   logic        s2_over_in, s2_over_ff;
   logic [22:0] s2_days_ff;

   assign s2_diff    = {1'b0, s1_t_ff} - (40'(s1_days_ff) * 40'(SECS_PER_DAY));
   assign s2_secs_in = s2_diff[16:0];
   assign s2_over_in = s1_days_ff > 23'(MAX_DAYS);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_days_ff <= s1_days_ff;
         s2_secs_ff <= s2_secs_in;
         s2_over_ff <= s2_over_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Saturate, shift to March-based day count, scale for the year estimate.
   logic [21:0] s3_days;
   logic [16:0] s3_secs_in, s3_secs_ff;
   logic [21:0] s3_d_in, s3_d_ff;
   logic [30:0] s3_n_in, s3_n_ff;
   logic [21:0] s3_wx_in, s3_wx_ff;

   assign s3_days    = s2_over_ff ? MAX_DAYS : s2_days_ff[21:0];
   assign s3_secs_in = s2_over_ff ? LAST_SEC_OF_DAY : s2_secs_ff;
   assign s3_d_in    = s3_days + MARCH_OFFSET;
   assign s3_n_in    = 31'(s3_days + MARCH_OFFSET_P2) * 31'd400;
   assign s3_wx_in   = s3_days + EPOCH_WEEKDAY;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_secs_ff <= s3_secs_in;
         s3_d_ff    <= s3_d_in;
         s3_n_ff    <= s3_n_in;
         s3_wx_ff   <= s3_wx_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Gauss year estimate (n / 146097), hour (secs / 3600), week count.
   logic [62:0] s4_yprod;
   logic [34:0] s4_hprod;
   logic [44:0] s4_wprod;
   logic [13:0] s4_y_ff;
   logic [4:0]  s4_hour_ff;
   logic [19:0] s4_q7_ff;
   logic [21:0] s4_d_ff, s4_wx_ff;
   logic [16:0] s4_secs_ff;

   assign s4_yprod = 63'(s3_n_ff) * 63'(RECIP_146097);
   assign s4_hprod = 35'(s3_secs_ff) * 35'(RECIP_3600);
   assign s4_wprod = 45'(s3_wx_ff) * 45'(RECIP_7);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_y_ff    <= s4_yprod[62:49];
         s4_hour_ff <= s4_hprod[33:29];
         s4_q7_ff   <= s4_wprod[44:25];
         s4_d_ff    <= s3_d_ff;
         s4_wx_ff   <= s3_wx_ff;
         s4_secs_ff <= s3_secs_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // Centuries of the estimate, seconds into the hour, weekday.
   logic [26:0] s5_cprod;
   logic [16:0] s5_hdiff;
   logic [21:0] s5_wdiff;
   logic [7:0]  s5_c_ff;
   logic [13:0] s5_y_ff;
   logic [21:0] s5_d_ff;
   logic [4:0]  s5_hour_ff;
   logic [11:0] s5_remh_ff;
   logic [2:0]  s5_wday_ff;

   assign s5_cprod = 27'(s4_y_ff) * 27'(RECIP_100);
   assign s5_hdiff = s4_secs_ff - (17'(s4_hour_ff) * 17'd3600);
   assign s5_wdiff = s4_wx_ff - (22'(s4_q7_ff) * 22'd7);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_c_ff    <= s5_cprod[26:19];
         s5_y_ff    <= s4_y_ff;
         s5_d_ff    <= s4_d_ff;
         s5_hour_ff <= s4_hour_ff;
         s5_remh_ff <= s5_hdiff[11:0];
         s5_wday_ff <= s5_wdiff[2:0];
      end
   end

   // ---------------------------------------------------------------- stage 6
   // Day-of-year against the estimated year; its leap flag; minute.
   logic [22:0] s6_base, s6_diff;
   logic        s6_leap_in, s6_leap_ff;
   logic [26:0] s6_mprod;
   logic [13:0] s6_y_ff;
   logic signed [10:0] s6_yday_ff;
   logic [4:0]  s6_hour_ff;
   logic [5:0]  s6_min_ff;
   logic [11:0] s6_remh_ff;
   logic [2:0]  s6_wday_ff;

   assign s6_base = (23'(s5_y_ff) * 23'd365) + 23'(s5_y_ff[13:2])
                    - 23'(s5_c_ff) + 23'(s5_c_ff[7:2]);
   assign s6_diff = 23'(s5_d_ff) - s6_base;
   assign s6_leap_in = (s5_y_ff[1:0] == 2'd0)
                       && ((15'(s5_y_ff) != (15'(s5_c_ff) * 15'd100))
                           || (s5_c_ff[1:0] == 2'd0));
   assign s6_mprod = 27'(s5_remh_ff) * 27'(RECIP_60);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_y_ff    <= s5_y_ff;
         s6_yday_ff <= signed'(s6_diff[10:0]);
         s6_leap_ff <= s6_leap_in;
         s6_hour_ff <= s5_hour_ff;
         s6_min_ff  <= s6_mprod[25:20];
         s6_remh_ff <= s5_remh_ff;
         s6_wday_ff <= s5_wday_ff;
      end
   end

   // ---------------------------------------------------------------- stage 7
   // Overshot estimate: step back one year. Second within the minute.
   logic [10:0] s7_fix;
   logic [8:0]  s7_yday_in, s7_yday_ff;
   logic [13:0] s7_y_in, s7_y_ff;
   logic [11:0] s7_sdiff;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_min_ff, s7_sec_ff;
   logic [2:0]  s7_wday_ff;

   assign s7_fix   = 11'(s6_yday_ff) + 11'd365 + 11'(s6_leap_ff);
   assign s7_sdiff = s6_remh_ff - (12'(s6_min_ff) * 12'd60);

   always_comb begin
      if (s6_yday_ff[10]) begin
         s7_yday_in = s7_fix[8:0];
         s7_y_in    = s6_y_ff - 14'd1;
      end else begin
         s7_yday_in = s6_yday_ff[8:0];
         s7_y_in    = s6_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_yday_ff <= s7_yday_in;
         s7_y_ff    <= s7_y_in;
         s7_hour_ff <= s6_hour_ff;
         s7_min_ff  <= s6_min_ff;
         s7_sec_ff  <= s7_sdiff[5:0];
         s7_wday_ff <= s6_wday_ff;
      end
   end

   // ---------------------------------------------------------------- stage 8
   // Month and day of month; result register.
   date_type    s8_date;
   logic [5:0]  rsp_second_ff, rsp_minute_ff;
   logic [4:0]  rsp_hour_ff, rsp_day_of_month_ff;
   logic [3:0]  rsp_month_ff;
   logic [13:0] rsp_year_ff;
   logic [2:0]  rsp_weekday_ff;

   e2u_month u_month (
      .yday       (s7_yday_ff),
      .march_year (s7_y_ff),
      .date       (s8_date)
   );

   always_ff @(posedge clock) begin
      if (en[7]) begin
         rsp_second_ff       <= s7_sec_ff;
         rsp_minute_ff       <= s7_min_ff;
         rsp_hour_ff         <= s7_hour_ff;
         rsp_day_of_month_ff <= s8_date.mday;
         rsp_month_ff        <= s8_date.month;
         rsp_year_ff         <= s8_date.year;
         rsp_weekday_ff      <= s7_wday_ff;
      end
   end

   assign rsp_second       = rsp_second_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_day_of_month = rsp_day_of_month_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_weekday      = rsp_weekday_ff;

endmodule

`default_nettype wire

### rtl/e2u_month.sv
// Month, day of month and calendar year from a March-based day-of-year.
`default_nettype none

module e2u_month
   import e2u_pkg::*;
(
   input  wire logic [8:0]  yday,
   input  wire logic [13:0] march_year,
   output date_type         date
);

   logic [3:0] cnt;
   logic [8:0] base;
   logic [8:0] mday_full;

   // Month index is one plus the number of month starts passed.
   always_comb begin
      cnt = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         if (yday >= month_base(4'(k))) begin
            cnt = cnt + 4'd1;
         end
      end
   end

   assign base      = month_base(cnt);
   assign mday_full = yday - base + 9'd1;

   always_comb begin
      date.mday = mday_full[4:0];
      if (yday >= MARCH_TO_DEC) begin
         // January and February belong to the next calendar year.
         date.year  = march_year + 14'd1;
         date.month = cnt - 4'd10;
      end else begin
         date.year  = march_year;
         date.month = cnt + 4'd2;
      end
   end

endmodule

`default_nettype wire

### tb/tb_epoch_seconds_to_utc_date.sv
// Testbench: self-checking stimulus and scoreboard for the epoch to UTC date converter.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_utc_date;
   import e2u_pkg::*;

   // Clock period and run limits.
   localparam int     CLOCK_PERIOD = 12;
   localparam int     RESET_CYCLES = 6;
   localparam longint CYCLE_LIMIT  = 400000;

   // Calendar constants for the predictor. These are kept signed so that the
   // day-of-year step can go negative before the leap correction.
   localparam longint DAY_SECONDS      = 86400;
   localparam longint LAST_DAY         = 2932896;     // 9999-12-31, days since epoch
   localparam longint LAST_SECOND      = 86399;
   localparam longint BC_MARCH_OFFSET  = 719527;
   localparam longint MARCH_TO_DEC_DAY = 306;
   localparam longint GAUSS_MONTH_MUL  = 367;
   localparam longint ERA_DAYS         = 146097;      // days in 400 years
   // Last stamp that is not saturated: 9999-12-31 23:59:59.
   localparam longint LAST_VALID_STAMP = LAST_DAY * DAY_SECONDS + LAST_SECOND;

   // One broken-down UTC result, fields at the widths of the rsp_ ports.
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [13:0] year;
      logic [2:0]  weekday;
   } utc_fields_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic signed [39:0] req_epoch_seconds = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [5:0]         rsp_second;
   logic [5:0]         rsp_minute;
   logic [4:0]         rsp_hour;
   logic [4:0]         rsp_day_of_month;
   logic [3:0]         rsp_month;
   logic [13:0]        rsp_year;
   logic [2:0]         rsp_weekday;

   // Dates still owed by the DUT, oldest first.
   utc_fields_type pending_dates[$];
   utc_fields_type oldest_date;
   int          error_count   = 0;
   longint      cycle_count   = 0;
   // Idle odds in percent for the sender and the receiver.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   epoch_seconds_to_utc_date DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_second        (rsp_second),
      .rsp_minute        (rsp_minute),
      .rsp_hour          (rsp_hour),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year),
      .rsp_weekday       (rsp_weekday)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Predict the UTC breakdown of one stamp. Negative stamps read as the
   // epoch; anything past the last day pins to its last second. The date
   // comes from Gauss's year estimate on days since 1 March 1 BC.
   function automatic utc_fields_type utc_breakdown(input logic signed [39:0] stamp);
      utc_fields_type fields;
      longint      t;
      longint      days;
      longint      secs;
      longint      d;
      longint      yr;
      longint      yday;
      longint      mon;
      longint      mday;
      bit          leap;
      t    = stamp[39] ? 64'sd0 : longint'(stamp);
      days = t / DAY_SECONDS;
      secs = t % DAY_SECONDS;
      if (days > LAST_DAY) begin
         days = LAST_DAY;
         secs = LAST_SECOND;
      end
      fields.weekday = 3'((4 + days) % 7);
      fields.hour    = 5'(secs / 3600);
      secs           = secs % 3600;
      fields.minute  = 6'(secs / 60);
      fields.second  = 6'(secs % 60);

      d    = days - 59 + BC_MARCH_OFFSET;
      yr   = (d + 2) * 400 / ERA_DAYS;
      yday = d - (365 * yr + yr / 4 - yr / 100 + yr / 400);
      // Year estimate one too high (late February): step back a year.
      if (yday < 0) begin
         leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
         yday = 365 + (leap ? 1 : 0) + yday;
         yr   = yr - 1;
      end
      mon  = (yday + 31) * 10 / MARCH_TO_DEC_DAY;
      mday = yday - (GAUSS_MONTH_MUL * mon / 12 - 30) + 1;
      // January and February belong to the next civil year.
      if (yday >= MARCH_TO_DEC_DAY) begin
         yr  = yr + 1;
         mon = mon - 10;
      end else begin
         mon = mon + 2;
      end
      fields.day_of_month = 5'(mday);
      fields.month        = 4'(mon);
      fields.year         = 14'(yr);
      return fields;
   endfunction

   // Send one stamp; random idle cycles first, then hold until the transfer.
   // Valid is only lowered when an idle gap is taken, so back-to-back
   // transfers keep it high without a second assignment in one step.
   task automatic send_stamp(input logic signed [39:0] stamp);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= stamp;
      do @(posedge clock); while (!req_ready);
      pending_dates.insert(pending_dates.size(), utc_breakdown(stamp));
   endtask

   // Random stamp, weighted toward the calendar range the DUT converts.
   function automatic logic signed [39:0] random_stamp();
      int unsigned     sel;
      longint unsigned wide;
      longint          day;
      sel  = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (sel < 50) begin
         // anywhere in 1970 .. 9999
         return 40'(longint'(wide % 64'(LAST_VALID_STAMP + 1)));
      end else if (sel < 68) begin
         // day edges: midnight, last second, or any second of a random day
         day = longint'(wide % 64'(LAST_DAY + 1));
         case ($urandom_range(0, 2))
            0:       return 40'(day * DAY_SECONDS);
            1:       return 40'(day * DAY_SECONDS + LAST_SECOND);
            default: return 40'(day * DAY_SECONDS + $urandom_range(0, 86399));
         endcase
      end else if (sel < 78) begin
         // first few centuries after the epoch
         return 40'(longint'(wide % 64'(DAY_SECONDS * 365 * 300)));
      end else if (sel < 86) begin
         // around the saturation point
         return 40'(LAST_VALID_STAMP - 200000 + longint'(wide % 64'd400000));
      end else if (sel < 93) begin
         return {1'b1, wide[38:0]};
      end else begin
         return wide[39:0];
      end
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Epoch itself and negative stamps, which clamp to the epoch.
   task automatic test_epoch_clamp();
      send_stamp(40'sd0);
      send_stamp(40'sd1);
      send_stamp(-40'sd1);
      send_stamp(-40'sd86400);
      send_stamp(40'h80_0000_0000);
   endtask

   // Minute, hour, day and year rollovers.
   task automatic test_time_rollover();
      send_stamp(40'sd59);
      send_stamp(40'sd60);
      send_stamp(40'sd3599);
      send_stamp(40'sd3600);
      send_stamp(40'sd86399);
      send_stamp(40'sd86400);
      send_stamp(40'sd946684799);     // 1999-12-31 23:59:59
      send_stamp(40'sd946684800);     // 2000-01-01
      send_stamp(40'sd2147483647);    // 2038-01-19 03:14:07
   endtask

   // Late February, where the year estimate overshoots, and leap rules.
   task automatic test_late_february();
      send_stamp(40'sd68083200);      // 1972-02-28
      send_stamp(40'sd68169600);      // 1972-02-29
      send_stamp(40'sd951782400);     // 2000-02-29
      send_stamp(40'sd951868799);     // 2000-02-29 23:59:59
      send_stamp(40'sd4107456000);    // 2100-02-28, no leap day
      send_stamp(40'sd4107542400);    // 2100-03-01
      send_stamp(40'sd13574563200);   // 2400-02-29
   endtask

   // Last unsaturated second, first saturated one, and the largest input.
   task automatic test_saturation();
      send_stamp(40'(LAST_VALID_STAMP));
      send_stamp(40'(LAST_VALID_STAMP + 1));
      send_stamp(40'h7F_FFFF_FFFF);
   endtask

   task automatic test_random_stamps(input int count);
      repeat (count) send_stamp(random_stamp());
   endtask

   // Receiver: ready drops at random per the current idle odds.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Scoreboard: every result transfer is matched to the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $error("unexpected result transfer: year %0d month %0d day %0d",
                   rsp_year, rsp_month, rsp_day_of_month);
            error_count++;
         end else begin
            oldest_date = pending_dates.pop_front();
            check_field("second",       oldest_date.second,       rsp_second);
            check_field("minute",       oldest_date.minute,       rsp_minute);
            check_field("hour",         oldest_date.hour,         rsp_hour);
            check_field("day_of_month", oldest_date.day_of_month, rsp_day_of_month);
            check_field("month",        oldest_date.month,        rsp_month);
            check_field("year",         oldest_date.year,         rsp_year);
            check_field("weekday",      oldest_date.weekday,      rsp_weekday);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_epoch_seconds_to_utc_date: errors");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: sender idles a little, receiver stalls half the time.
      send_idle_pct = 21;
      recv_idle_pct = 51;
      test_epoch_clamp();
      test_time_rollover();
      test_late_february();
      test_saturation();
      test_random_stamps(530);

      // Phase two: swap the odds, so the pipeline mostly runs empty.
      send_idle_pct = 51;
      recv_idle_pct = 21;
      test_random_stamps(550);

      // Phase three: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stamps(550);
      req_valid <= 1'b0;

      // Drain, then give the pipeline time to show any stray transfer.
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (4 * PIPE_STAGES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_epoch_seconds_to_utc_date: clean");
      end else begin
         $display("tb_epoch_seconds_to_utc_date: errors");
      end
      $finish;
   end

endmodule
